// ----- rtl/lcgrng_pkg.sv -----
// ----------------------------------------------------------------------------
// lcgrng_pkg
// Shared constants, types and the modular fold for the combined lcg rng.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgrng_pkg;

	// shuffle table
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int WARMUP      = TABLE_DEPTH + 8;
	localparam int CNT_W       = $clog2(WARMUP);

	// generators: modulus = 2^31 - fold constant
	localparam logic [30:0] MOD_ONE  = 31'd2147483563;
	localparam logic [30:0] MOD_TWO  = 31'd2147483399;
	localparam logic [15:0] MUL_ONE  = 16'd40014;
	localparam logic [15:0] MUL_TWO  = 16'd40692;
	localparam logic [7:0]  FOLD_ONE = 8'd85;
	localparam logic [7:0]  FOLD_TWO = 8'd249;
	localparam logic [30:0] G2_INIT  = 31'd123456789;
	localparam int          PROD_W   = 47;

	// output wrap and bin size
	localparam logic [31:0] SPAN = 32'(MOD_ONE) - 32'd1;
	localparam logic [31:0] BIN  = 32'd1 + SPAN / 32'(TABLE_DEPTH);

	// index by reciprocal multiply, one correction step
	localparam int          QSH   = 40;
	localparam int          QW    = $clog2(TABLE_DEPTH + 1);
	localparam int          QP_W  = QSH + QW;
	localparam logic [63:0] RECIP = (64'd1 << QSH) / 64'(BIN);

	// configuration port
	localparam int          ADDR_W   = 3;
	localparam logic        REG_SEED = 1'b0;

	// datapath controls for one step
	typedef struct packed {
		logic ld_seed;
		logic mul1;
		logic mul2;
		logic red1;
		logic red2;
		logic qmul;
		logic qfix;
		logic rd;
		logic seed_wr;
		logic finish;
	} ctl_t;

	// datapath status back to the sequencer
	typedef struct packed {
		logic pending;
		logic cnt_zero;
		logic out_busy;
	} stat_t;

	// x mod (2^31 - c) for x < 2^47: fold the high part, then one subtract
	function automatic logic [30:0] mod_fold(input logic [PROD_W-1:0] p,
		input logic [7:0] c, input logic [30:0] m);
		logic [31:0] t;
		t = 32'(p[PROD_W-1:31]) * 32'(c) + 32'(p[30:0]);
		if (t >= 32'(m)) begin
			t = t - 32'(m);
		end
		return t[30:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/lcgrng_seq.sv -----
// ----------------------------------------------------------------------------
// lcgrng_seq
// Microcode sequencer: step counter, control rom and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgrng_seq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               reseed,
	input  wire lcgrng_pkg::stat_t  stat,
	output logic                    in_ready,
	output lcgrng_pkg::ctl_t        ctl
);

	localparam logic [1:0] C_NEXT   = 2'd0;
	localparam logic [1:0] C_ACCEPT = 2'd1;
	localparam logic [1:0] C_LOOP   = 2'd2;
	localparam logic [1:0] C_OUT    = 2'd3;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RS0  = 3'd1;
	localparam logic [2:0] S_RS1  = 3'd2;
	localparam logic [2:0] S_RS2  = 3'd3;
	localparam logic [2:0] S_D0   = 3'd4;
	localparam logic [2:0] S_D1   = 3'd5;
	localparam logic [2:0] S_D2   = 3'd6;
	localparam logic [2:0] S_D3   = 3'd7;

	typedef struct packed {
		lcgrng_pkg::ctl_t ops;
		logic [1:0]       cond;
		logic [2:0]       target;
	} uop_t;

	logic [2:0] pc_q;
	logic [2:0] pc_nxt;
	uop_t       uop;

	// control rom
	always_comb begin
		uop = '0;
		unique case (pc_q)
			S_IDLE: begin
				uop.cond   = C_ACCEPT;
				uop.target = S_D0;
			end
			S_RS0: begin
				uop.ops.ld_seed = 1'b1;
			end
			S_RS1: begin
				uop.ops.mul1 = 1'b1;
			end
			S_RS2: begin
				uop.ops.red1    = 1'b1;
				uop.ops.seed_wr = 1'b1;
				uop.cond        = C_LOOP;
				uop.target      = S_RS1;
			end
			S_D0: begin
				uop.ops.mul1 = 1'b1;
				uop.ops.mul2 = 1'b1;
				uop.ops.qmul = 1'b1;
			end
			S_D1: begin
				uop.ops.red1 = 1'b1;
				uop.ops.red2 = 1'b1;
				uop.ops.qfix = 1'b1;
			end
			S_D2: begin
				uop.ops.rd = 1'b1;
			end
			S_D3: begin
				uop.ops.finish = 1'b1;
				uop.cond       = C_OUT;
				uop.target     = S_IDLE;
			end
			default: uop = '0;
		endcase
	end

	// jump logic
	always_comb begin
		pc_nxt = pc_q + 3'd1;
		unique case (uop.cond)
			C_NEXT: pc_nxt = pc_q + 3'd1;
			C_ACCEPT: begin
				if (!in_valid) begin
					pc_nxt = pc_q;
				end else if (reseed || stat.pending) begin
					pc_nxt = pc_q + 3'd1;
				end else begin
					pc_nxt = uop.target;
				end
			end
			C_LOOP: begin
				if (!stat.cnt_zero) begin
					pc_nxt = uop.target;
				end else begin
					pc_nxt = pc_q + 3'd1;
				end
			end
			C_OUT: begin
				if (stat.out_busy) begin
					pc_nxt = pc_q;
				end else begin
					pc_nxt = uop.target;
				end
			end
			default: pc_nxt = pc_q + 3'd1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_nxt;
		end
	end

	assign in_ready = (uop.cond == C_ACCEPT);

	// the result write waits while the output register is still full
	always_comb begin
		ctl        = uop.ops;
		ctl.finish = uop.ops.finish && !stat.out_busy;
	end

endmodule

`default_nettype wire

// ----- rtl/lcgrng_dp.sv -----
// ----------------------------------------------------------------------------
// lcgrng_dp
// Datapath: generator lanes, index unit, shuffle table and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgrng_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lcgrng_pkg::ctl_t  ctl,
	input  wire logic [30:0]       seed,
	input  wire logic              out_ready,
	output lcgrng_pkg::stat_t      stat,
	output logic                   out_valid,
	output logic [30:0]            sample
);

	logic [30:0] g1_q;
	logic [30:0] g2_q;
	logic [30:0] last_q;
	logic        pending_q;
	logic [lcgrng_pkg::CNT_W-1:0] cnt_q;
	logic [lcgrng_pkg::PROD_W-1:0] p1_q;
	logic [lcgrng_pkg::PROD_W-1:0] p2_q;
	logic [lcgrng_pkg::QP_W-1:0] qp_q;
	logic [lcgrng_pkg::IDX_W-1:0] idx_q;
	logic [30:0] rd_q;
	logic        out_valid_q;
	logic [30:0] sample_q;

	logic [30:0] table_q [lcgrng_pkg::TABLE_DEPTH];

	logic [30:0] r1;
	logic [30:0] r2;
	logic [30:0] seed_m;
	logic [30:0] seed_s;
	logic [lcgrng_pkg::QW-1:0] q0;
	logic [lcgrng_pkg::QW+31:0] next_bound;
	logic [lcgrng_pkg::QW:0] q1;
	logic [lcgrng_pkg::IDX_W-1:0] idx_nxt;
	logic [31:0] diff;
	logic [30:0] result;
	logic        wr_en;
	logic [lcgrng_pkg::IDX_W-1:0] wr_addr;
	logic [30:0] wr_data;

	assign r1 = lcgrng_pkg::mod_fold(p1_q, lcgrng_pkg::FOLD_ONE, lcgrng_pkg::MOD_ONE);
	assign r2 = lcgrng_pkg::mod_fold(p2_q, lcgrng_pkg::FOLD_TWO, lcgrng_pkg::MOD_TWO);

	// seed mod first modulus, zero becomes one
	always_comb begin
		seed_m = (seed >= lcgrng_pkg::MOD_ONE) ? (seed - lcgrng_pkg::MOD_ONE) : seed;
		seed_s = (seed_m == 31'd0) ? 31'd1 : seed_m;
	end

	// quotient estimate is low by at most one
	always_comb begin
		q0 = qp_q[lcgrng_pkg::QSH +: lcgrng_pkg::QW];
		next_bound = ((lcgrng_pkg::QW+32)'(q0) + (lcgrng_pkg::QW+32)'(1))
			* (lcgrng_pkg::QW+32)'(lcgrng_pkg::BIN);
		q1 = (lcgrng_pkg::QW+1)'(q0);
		if ((lcgrng_pkg::QW+32)'(last_q) >= next_bound) begin
			q1 = q1 + (lcgrng_pkg::QW+1)'(1);
		end
		if (q1 >= (lcgrng_pkg::QW+1)'(lcgrng_pkg::TABLE_DEPTH)) begin
			idx_nxt = lcgrng_pkg::IDX_W'(lcgrng_pkg::TABLE_DEPTH - 1);
		end else begin
			idx_nxt = q1[lcgrng_pkg::IDX_W-1:0];
		end
	end

	// entry minus second generator, wrapped
	always_comb begin
		diff = 32'(rd_q) - 32'(g2_q);
		if (rd_q <= g2_q) begin
			diff = diff + lcgrng_pkg::SPAN;
		end
		result = diff[30:0];
	end

	// one table write port shared by warm-up fill and draws
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = g1_q;
		if (ctl.finish) begin
			wr_en = 1'b1;
		end else if (ctl.seed_wr &&
			(cnt_q < lcgrng_pkg::CNT_W'(lcgrng_pkg::TABLE_DEPTH))) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q[lcgrng_pkg::IDX_W-1:0];
			wr_data = r1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_q <= table_q[idx_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.mul1) begin
			p1_q <= lcgrng_pkg::PROD_W'(g1_q) * lcgrng_pkg::PROD_W'(lcgrng_pkg::MUL_ONE);
		end
		if (ctl.mul2) begin
			p2_q <= lcgrng_pkg::PROD_W'(g2_q) * lcgrng_pkg::PROD_W'(lcgrng_pkg::MUL_TWO);
		end
		if (ctl.qmul) begin
			qp_q <= lcgrng_pkg::QP_W'(last_q) * lcgrng_pkg::QP_W'(lcgrng_pkg::RECIP);
		end
		if (ctl.qfix) begin
			idx_q <= idx_nxt;
		end
		if (ctl.finish) begin
			sample_q <= result;
		end
	end

	// generator state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g1_q        <= 31'd0;
			g2_q        <= lcgrng_pkg::G2_INIT;
			last_q      <= 31'd0;
			pending_q   <= 1'b1;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.ld_seed) begin
				g1_q  <= seed_s;
				g2_q  <= seed_s;
				cnt_q <= lcgrng_pkg::CNT_W'(lcgrng_pkg::WARMUP - 1);
			end
			if (ctl.red1) begin
				g1_q <= r1;
			end
			if (ctl.red2) begin
				g2_q <= r2;
			end
			if (ctl.seed_wr) begin
				if (cnt_q == '0) begin
					last_q    <= r1;
					pending_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - lcgrng_pkg::CNT_W'(1);
				end
			end
			if (ctl.finish) begin
				last_q      <= result;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.pending  = pending_q;
	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign sample        = sample_q;

endmodule

`default_nettype wire

// ----- rtl/combined_lcg_shuffle_rng.sv -----
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Combined two-generator lcg with a shuffle table, one 31-bit sample a word.
// a plain draw runs the idle step plus four draw steps (multiply, reduce, table
//   read, result write, which waits while the output is busy); no new request
//   is taken until the result write; a reseed (flag set, or first draw after
//   reset) adds the seed load and 40 multiply/fold pairs of the first generator lane
// reset clears the sequencer and marks a seed pending; the table is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module combined_lcg_shuffle_rng (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// apb configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lcgrng_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// request words
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          reseed,
	// sample words
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [30:0]                        sample
);

	logic [30:0]       seed_q;
	logic              wr_fire;
	lcgrng_pkg::ctl_t  ctl;
	lcgrng_pkg::stat_t stat;

	// apb: always ready, write lands on the access phase
	assign pready  = 1'b1;
	assign wr_fire = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 31'd0;
		end else if (wr_fire && (paddr[2] == lcgrng_pkg::REG_SEED)) begin
			seed_q <= pwdata[30:0];
		end
	end

	// read back the seed wherever paddr[2] is clear; addresses with paddr[2] set read zero
	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == lcgrng_pkg::REG_SEED) begin
			prdata = {1'b0, seed_q};
		end
	end

	// sequencer walks the rom, datapath does the arithmetic
	lcgrng_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.reseed   (reseed),
		.stat     (stat),
		.in_ready (in_ready),
		.ctl      (ctl)
	);

	lcgrng_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.seed      (seed_q),
		.out_ready (out_ready),
		.stat      (stat),
		.out_valid (out_valid),
		.sample    (sample)
	);

endmodule

`default_nettype wire
